// ===== rtl/dna_kmer_histogram_macros.svh =====
// Assertion helpers for the k-mer histogram RTL.
// Each macro expects clk and rst_n in the enclosing scope.
`ifndef DNA_KMER_HISTOGRAM_MACROS_SVH
`define DNA_KMER_HISTOGRAM_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DKH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dkh: same-cycle check failed");
// next-cycle implication
`define DKH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dkh: next-cycle check failed");
`else
`define DKH_ASSERT_IMP(lbl, ante, cons)
`define DKH_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/dkh_pkg.sv =====
`default_nettype none

package dkh_pkg;

    // field widths
    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int BIN_W   = 20;
    localparam int COUNT_W = 32;
    localparam int WL_W    = 4;
    localparam int RUN_W   = 4;

    // histogram size, log2
    localparam int DKH_BIN_BITS = 20;

    localparam logic [WL_W-1:0]  WL_RESET = 4'd10;
    localparam logic [RUN_W-1:0] RUN_MAX  = 4'd15;

    // operation codes
    localparam logic [OP_W-1:0] OP_FEED     = 2'd0;
    localparam logic [OP_W-1:0] OP_READ     = 2'd1;
    localparam logic [OP_W-1:0] OP_NEW_FILE = 2'd2;

    // characters of interest
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'd62;
    localparam logic [CHAR_W-1:0] CH_AT    = 8'd64;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'd65;
    localparam logic [CHAR_W-1:0] CH_UP_C  = 8'd67;
    localparam logic [CHAR_W-1:0] CH_UP_G  = 8'd71;
    localparam logic [CHAR_W-1:0] CH_UP_T  = 8'd84;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LO_C  = 8'd99;
    localparam logic [CHAR_W-1:0] CH_LO_G  = 8'd103;
    localparam logic [CHAR_W-1:0] CH_LO_T  = 8'd116;
    localparam logic [CHAR_W-1:0] CH_HIGH  = 8'd128;

    typedef struct packed {
        logic       is_base;
        logic [1:0] code;
    } base_t;

    function automatic base_t base_lookup(input logic [CHAR_W-1:0] b);
        base_t r;
        r.is_base = 1'b1;
        r.code    = 2'd0;
        case (b)
            CH_UP_A, CH_LO_A: r.code = 2'd0;
            CH_UP_C, CH_LO_C: r.code = 2'd1;
            CH_UP_G, CH_LO_G: r.code = 2'd2;
            CH_UP_T, CH_LO_T: r.code = 2'd3;
            default:          r.is_base = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dkh_ram.sv =====
`default_nettype none

// Simple dual-port RAM, registered read, old data on read/write collision.
module dkh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/dkh_parser.sv =====
`default_nettype none

// Header/sequence parser and rolling 2-bit base index.
module dkh_parser
    import dkh_pkg::*;
#(
    parameter int AW = DKH_BIN_BITS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              feed,
    input  wire logic              restart,
    input  wire logic [CHAR_W-1:0] char_byte,
    input  wire logic [WL_W-1:0]   word_length,
    output logic                   count_en,
    output logic      [AW-1:0]     count_addr
);

    logic              in_seq_reg,  in_seq_next;
    logic [AW-1:0]     rolling_reg, rolling_next;
    logic [RUN_W-1:0]  run_reg,     run_next;
    base_t             base;

    assign base = base_lookup(char_byte);

    always_comb
    begin
        in_seq_next  = in_seq_reg;
        rolling_next = rolling_reg;
        run_next     = run_reg;
        count_en     = 1'b0;
        if (restart)
        begin
            in_seq_next  = 1'b0;
            rolling_next = '0;
            run_next     = '0;
        end
        else if (feed)
        begin
            if (!in_seq_reg)
            begin
                if (char_byte inside {CH_LF, CH_CR})
                begin
                    in_seq_next = 1'b1;
                end
            end
            else if (char_byte inside {CH_GT, CH_AT, CH_PLUS})
            begin
                in_seq_next  = 1'b0;
                rolling_next = '0;
                run_next     = '0;
            end
            else if (char_byte <= CH_AT || char_byte >= CH_HIGH)
            begin
                // ignored
            end
            else if (base.is_base)
            begin
                // only the low AW bits matter: the bin is the index mod 2**AW
                rolling_next = AW'({rolling_reg, base.code});
                run_next     = (run_reg == RUN_MAX) ? run_reg : run_reg + 1'b1;
                count_en     = (run_next >= word_length);
            end
            else
            begin
                rolling_next = '0;
                run_next     = '0;
            end
        end
    end

    assign count_addr = rolling_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_seq_reg  <= 1'b0;
            rolling_reg <= '0;
            run_reg     <= '0;
        end
        else
        begin
            in_seq_reg  <= in_seq_next;
            rolling_reg <= rolling_next;
            run_reg     <= run_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dna_kmer_histogram.sv =====
// k-mer histogram over a byte stream of a FASTA/FASTQ-style file.
// Input channel (in_valid/in_stall): one transaction per operation;
//   operation FEED takes char_byte, READ takes bin_index, NEW_FILE restarts
//   the parser (histogram kept). Unused operation code is a no-op.
// Output channel (out_valid/out_stall): one transaction per READ, carrying
//   bin_number (echo of bin_index) and bin_count (0 if beyond the table).
// Config: cfg_write/cfg_data sets word_length (reset 10); write while idle.
// Throughput: one transaction per cycle for any mix of operations while in_stall is low.
//   The histogram lives in one dual-port RAM: read at acceptance, count and
//   write back in the next cycle; a write-data register forwards the value of
//   the previous cycle's write, so back-to-back hits on one bin are exact.
// Read path: an accepted READ passes stage 1, then enters the output buffer behind out_valid.
// Reset: parser state and word_length return to defaults, then a clearing
//   pass zeroes all 2**BIN_BITS entries (1,048,576 by default) with
//   in_stall held high. Config writes are taken during the pass.
// Receiver stall: results queue in a two-entry output buffer; in_stall rises
//   only when that buffer plus the read in flight would overflow.
`default_nettype none
`include "dna_kmer_histogram_macros.svh"

module dna_kmer_histogram
    import dkh_pkg::*;
#(
    parameter int BIN_BITS = DKH_BIN_BITS   // 2..24
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [WL_W-1:0]    cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [OP_W-1:0]    operation,
    input  wire logic [CHAR_W-1:0]  char_byte,
    input  wire logic [BIN_W-1:0]   bin_index,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic      [BIN_W-1:0]   bin_number,
    output logic      [COUNT_W-1:0] bin_count
);

    localparam int AW   = BIN_BITS;
    localparam int BINS = 1 << BIN_BITS;

    // ---------------- configuration ----------------
    logic [WL_W-1:0] word_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_length_reg <= WL_RESET;
        end
        else if (cfg_write)
        begin
            word_length_reg <= cfg_data;
        end
    end

    // ---------------- input accept ----------------
    logic in_accept;
    logic is_read;
    logic count_en;
    logic [AW-1:0] count_addr;

    assign in_accept = in_valid && !in_stall;
    assign is_read   = in_accept && (operation == OP_READ);

    dkh_parser #(
        .AW (AW)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .feed        (in_accept && (operation == OP_FEED)),
        .restart     (in_accept && (operation == OP_NEW_FILE)),
        .char_byte   (char_byte),
        .word_length (word_length_reg),
        .count_en    (count_en),
        .count_addr  (count_addr)
    );

    // ---------------- clearing pass ----------------
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1)
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // ---------------- histogram RAM ----------------
    logic [AW-1:0]      rd_addr;
    logic               rd_oob;
    logic [COUNT_W-1:0] ram_rdata;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [COUNT_W-1:0] ram_wdata;

    // read at acceptance: bin to read, or bin to bump
    assign rd_addr = is_read ? AW'(bin_index) : count_addr;
    assign rd_oob  = (bin_index >> AW) != '0;

    // stage 1: RAM data available
    logic               s1_cnt_reg;
    logic               s1_rd_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic [BIN_W-1:0]   s1_num_reg;
    logic               s1_oob_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_cnt_reg <= 1'b0;
            s1_rd_reg  <= 1'b0;
        end
        else
        begin
            s1_cnt_reg <= count_en;
            s1_rd_reg  <= is_read;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= rd_addr;
        s1_num_reg  <= bin_index;
        s1_oob_reg  <= rd_oob;
    end

    // forwarding of last cycle's write (RAM returns old data on collision)
    logic               wr_valid_reg;
    logic [AW-1:0]      wr_addr_reg;
    logic [COUNT_W-1:0] wr_data_reg;
    logic [COUNT_W-1:0] fwd_data;
    logic [COUNT_W-1:0] inc_data;

    assign fwd_data = (wr_valid_reg && (wr_addr_reg == s1_addr_reg)) ? wr_data_reg : ram_rdata;
    assign inc_data = (fwd_data == '1) ? fwd_data : fwd_data + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            wr_valid_reg <= s1_cnt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= s1_addr_reg;
        wr_data_reg <= inc_data;
    end

    assign ram_we    = clr_active_reg || s1_cnt_reg;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : s1_addr_reg;
    assign ram_wdata = clr_active_reg ? '0 : inc_data;

    dkh_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (BINS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // ---------------- output buffer (two entries) ----------------
    logic [1:0]         out_count_reg, out_count_next;
    logic [BIN_W-1:0]   head_num_reg,  skid_num_reg;
    logic [COUNT_W-1:0] head_cnt_reg,  skid_cnt_reg;
    logic               out_pop;
    logic               out_push;
    logic [COUNT_W-1:0] push_cnt;
    logic [2:0]         occ_next;

    assign out_pop  = out_valid && !out_stall;
    assign out_push = s1_rd_reg;
    assign push_cnt = s1_oob_reg ? '0 : fwd_data;

    assign out_count_next = out_count_reg + {1'b0, out_push} - {1'b0, out_pop};

    // a read accepted now passes stage 1 before it lands in the buffer
    assign occ_next = {1'b0, out_count_reg} + {2'b00, s1_rd_reg} - {2'b00, out_pop};
    assign in_stall = clr_active_reg || (occ_next >= 3'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_count_reg <= '0;
        end
        else
        begin
            out_count_reg <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (out_count_reg)
            2'd0:
            begin
                if (out_push)
                begin
                    head_num_reg <= s1_num_reg;
                    head_cnt_reg <= push_cnt;
                end
            end
            2'd1:
            begin
                if (out_push && out_pop)
                begin
                    head_num_reg <= s1_num_reg;
                    head_cnt_reg <= push_cnt;
                end
                else if (out_push)
                begin
                    skid_num_reg <= s1_num_reg;
                    skid_cnt_reg <= push_cnt;
                end
            end
            2'd2:
            begin
                if (out_pop)
                begin
                    head_num_reg <= skid_num_reg;
                    head_cnt_reg <= skid_cnt_reg;
                    if (out_push)
                    begin
                        skid_num_reg <= s1_num_reg;
                        skid_cnt_reg <= push_cnt;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid  = (out_count_reg != 2'd0);
    assign bin_number = head_num_reg;
    assign bin_count  = head_cnt_reg;

    // ---------------- checks ----------------
    `DKH_ASSERT_IMP(a_clr_blocks_input, clr_active_reg, in_stall && !s1_cnt_reg && !s1_rd_reg)
    `DKH_ASSERT_IMP(a_buf_no_overflow, (out_count_reg == 2'd2) && !out_pop, !s1_rd_reg)
    `DKH_ASSERT_NXT(a_push_shows, s1_rd_reg && !out_pop, out_valid)
    `DKH_ASSERT_NXT(a_pop_drains, (out_count_reg == 2'd1) && out_pop && !s1_rd_reg, !out_valid)

endmodule

`default_nettype wire

// ===== tb/tb_dna_kmer_histogram.sv =====
// Expected-count model and checker for the k-mer histogram.
class kmer_scoreboard;
    typedef struct packed {
        logic [dkh_pkg::BIN_W-1:0]   number;
        logic [dkh_pkg::COUNT_W-1:0] count;
    } bin_read_t;

    logic [dkh_pkg::WL_W-1:0]    word_length;
    logic                        in_sequence;
    logic [31:0]                 rolling;
    logic [dkh_pkg::RUN_W-1:0]   run_length;
    logic [dkh_pkg::COUNT_W-1:0] counts [bit [dkh_pkg::BIN_W-1:0]];
    logic [dkh_pkg::BIN_W-1:0]   recent_bins[$];
    bin_read_t                   pending_reads[$];
    int                          mismatches;
    int                          reads_checked;
    int                          words_counted;

    function new();
        word_length   = dkh_pkg::WL_RESET;
        mismatches    = 0;
        reads_checked = 0;
        words_counted = 0;
        restart_parser();
    endfunction

    function void restart_parser();
        in_sequence = 1'b0;
        rolling     = '0;
        run_length  = '0;
    endfunction

    // One file byte through the parser; returns 1 if any state moved.
    function bit tally_byte(logic [dkh_pkg::CHAR_W-1:0] ch);
        logic [1:0]                code;
        logic [dkh_pkg::BIN_W-1:0] bin;
        if (!in_sequence)
        begin
            if (ch == dkh_pkg::CH_LF || ch == dkh_pkg::CH_CR)
            begin
                in_sequence = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        end
        if (ch == dkh_pkg::CH_GT || ch == dkh_pkg::CH_AT || ch == dkh_pkg::CH_PLUS)
        begin
            restart_parser();
            return 1'b1;
        end
        if (ch <= dkh_pkg::CH_AT || ch >= dkh_pkg::CH_HIGH)
            return 1'b0;
        case (ch)
            dkh_pkg::CH_UP_A, dkh_pkg::CH_LO_A: code = 2'd0;
            dkh_pkg::CH_UP_C, dkh_pkg::CH_LO_C: code = 2'd1;
            dkh_pkg::CH_UP_G, dkh_pkg::CH_LO_G: code = 2'd2;
            dkh_pkg::CH_UP_T, dkh_pkg::CH_LO_T: code = 2'd3;
            default:
            begin
                // non-base letter breaks the run
                rolling    = '0;
                run_length = '0;
                return 1'b1;
            end
        endcase
        rolling = {rolling[29:0], code};
        if (run_length != dkh_pkg::RUN_MAX)
            run_length++;
        if (run_length >= word_length)
        begin
            bin = rolling[dkh_pkg::BIN_W-1:0];
            if (!counts.exists(bin))
                counts[bin] = '0;
            if (counts[bin] != '1)
                counts[bin]++;
            words_counted++;
            recent_bins.push_back(bin);
            if (recent_bins.size() > 16)
                void'(recent_bins.pop_front());
        end
        return 1'b1;
    endfunction

    // Accepted input transaction; returns 1 unless the block just ignores it.
    function bit note_transaction(logic [dkh_pkg::OP_W-1:0]   op,
                                  logic [dkh_pkg::CHAR_W-1:0] ch,
                                  logic [dkh_pkg::BIN_W-1:0]  idx);
        bin_read_t exp;
        case (op)
            dkh_pkg::OP_FEED:
                return tally_byte(ch);
            dkh_pkg::OP_READ:
            begin
                exp.number = idx;
                exp.count  = counts.exists(idx) ? counts[idx] : '0;
                pending_reads.push_back(exp);
                return 1'b1;
            end
            dkh_pkg::OP_NEW_FILE:
            begin
                restart_parser();
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function void check_bin_read(logic [dkh_pkg::BIN_W-1:0]   number,
                                 logic [dkh_pkg::COUNT_W-1:0] count);
        bin_read_t exp;
        if (pending_reads.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected read result: bin %05h count %0d", number, count);
            return;
        end
        exp = pending_reads.pop_front();
        reads_checked++;
        if (number !== exp.number || count !== exp.count)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: bin read: expected bin %05h count %0d, got bin %05h count %0d",
                         exp.number, exp.count, number, count);
        end
    endfunction

    // A bin that was counted lately, or now and then any bin.
    function logic [dkh_pkg::BIN_W-1:0] hot_bin();
        logic [31:0] rnd;
        rnd = $urandom();
        if (recent_bins.size() == 0 || $urandom_range(0, 3) == 0)
            return rnd[dkh_pkg::BIN_W-1:0];
        return recent_bins[$urandom_range(0, recent_bins.size() - 1)];
    endfunction
endclass

module tb_dna_kmer_histogram;
    import dkh_pkg::*;

    // unused operation code: block must treat it as a no-op
    localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
    localparam logic [CHAR_W-1:0] CH_DEL    = 8'd127;
    localparam int CLK_HALF       = 6;
    // the clearing pass alone zeroes 2**20 bins; the rest of the run is far shorter
    localparam int TIMEOUT_CYCLES = 6_000_000;
    localparam int PHASE_ITEMS    = 106;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [WL_W-1:0]      cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [OP_W-1:0]      operation;
    logic [CHAR_W-1:0]    char_byte;
    logic [BIN_W-1:0]     bin_index;
    logic                 out_valid;
    logic                 out_stall;
    logic [BIN_W-1:0]     bin_number;
    logic [COUNT_W-1:0]   bin_count;

    kmer_scoreboard sb;

    // idle modes, switched per phase
    bit feed_gaps;
    bit result_stalls;
    int effective_items;
    int sent_items;

    dna_kmer_histogram i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .char_byte  (char_byte),
        .bin_index  (bin_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bin_number (bin_number),
        .bin_count  (bin_count)
    );

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Drive one input transaction and wait for it to be taken.
    // All drives happen at a rising edge; the handshake is sampled at the next
    // edges, so in_valid stays high across back-to-back transactions.
    task automatic send_transaction(input logic [OP_W-1:0]   op,
                                    input logic [CHAR_W-1:0] ch,
                                    input logic [BIN_W-1:0]  idx);
        int gap;
        gap = feed_gaps ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        char_byte <= ch;
        bin_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_items++;
        if (sb.note_transaction(op, ch, idx))
            effective_items++;
    endtask

    // unused payload fields get random bits so every input bit toggles
    task automatic feed(input logic [CHAR_W-1:0] ch);
        send_transaction(OP_FEED, ch, BIN_W'($urandom()));
    endtask

    task automatic read_bin(input logic [BIN_W-1:0] idx);
        send_transaction(OP_READ, CHAR_W'($urandom()), idx);
    endtask

    // style 0/1: any base in either case; 2: A only (same bin over and over,
    // exercises the read-modify-write forwarding); 3: A or C.
    function automatic logic [CHAR_W-1:0] random_base(input int style);
        logic [CHAR_W-1:0] pick;
        case ($urandom_range(0, 3))
            0: pick = CH_UP_A;
            1: pick = CH_UP_C;
            2: pick = CH_UP_G;
            default: pick = CH_UP_T;
        endcase
        if (style == 2)
            pick = CH_UP_A;
        else if (style == 3)
            pick = $urandom_range(0, 1) ? CH_UP_A : CH_UP_C;
        // lower case is upper case plus 32
        if ($urandom_range(0, 1))
            pick = pick | 8'h20;
        return pick;
    endfunction

    // One FASTA or FASTQ-like record: marker, header text, line break, a few
    // sequence lines with the odd non-base letter and interleaved bin reads.
    task automatic send_record();
        int  style;
        bit  fastq;
        fastq = ($urandom_range(0, 2) == 0);
        style = $urandom_range(0, 3);
        feed(fastq ? CH_AT : CH_GT);
        repeat ($urandom_range(0, 4))
            feed(CHAR_W'($urandom_range(33, 126)));
        feed($urandom_range(0, 1) ? CH_LF : CH_CR);
        repeat ($urandom_range(1, 3))
        begin
            repeat ($urandom_range(4, 30))
            begin
                case ($urandom_range(0, 39))
                    0: feed(CHAR_W'($urandom_range(CH_UP_A, CH_DEL)));
                    1, 2: read_bin(sb.hot_bin());
                    default: feed(random_base(style));
                endcase
            end
            feed(CH_LF);
        end
        if (fastq)
        begin
            // separator line drops back to header mode until its line break
            feed(CH_PLUS);
            repeat ($urandom_range(0, 10))
                feed(CHAR_W'($urandom_range(33, 126)));
            feed(CH_LF);
        end
        repeat ($urandom_range(0, 2))
            read_bin(sb.hot_bin());
    endtask

    task automatic run_phase(input int quota);
        int start;
        int r;
        start = sent_items;
        while (sent_items - start < quota)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                send_record();
            else if (r < 80)
                read_bin(sb.hot_bin());
            else if (r < 93)
                feed(CHAR_W'($urandom()));
            else
                send_transaction(OP_W'($urandom_range(OP_NEW_FILE, OP_UNUSED)),
                                 CHAR_W'($urandom()), BIN_W'($urandom()));
        end
    endtask

    // Sender pauses until every read result is back, then lets any feed still
    // in the RAM pipeline retire before a register write.
    task automatic drain();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (sb.pending_reads.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_word_length(input logic [WL_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.word_length = value;
    endtask

    // Result side: per result, optionally hold out_stall for a random count.
    initial
    begin : result_sink
        int hold;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = result_stalls ? $urandom_range(0, 15) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            sb.check_bin_read(bin_number, bin_count);
        end
    end

    initial
    begin : stimulus
        string             bases;
        logic [WL_W-1:0]   plan[8];
        int                i;
        sb = new();
        bases = "ACGTacgtACG";
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        operation <= OP_FEED;
        char_byte <= '0;
        bin_index <= '0;
        feed_gaps       = 1'b0;
        result_stalls   = 1'b1;
        effective_items = 0;
        sent_items      = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset word length of 10. The first transaction
        // waits out the clearing pass through in_stall.
        feed(8'h68);               // header text, ignored
        feed(CH_GT);               // marker in header mode is ignored too
        feed(CH_CR);               // CR enters sequence mode
        for (i = 0; i < bases.len(); i++)
            feed(bases[i]);        // tenth and eleventh bases count words
        read_bin(sb.recent_bins[$]);
        read_bin(sb.recent_bins[0]);
        feed(8'h4E);               // N breaks the run
        feed(8'h00);               // low byte ignored
        feed(8'hFF);               // high bytes ignored in sequence mode
        feed(CH_HIGH);
        feed(CH_AT);               // back to header mode
        feed(CH_LF);
        feed(CH_PLUS);
        send_transaction(OP_UNUSED, 8'hFF, '1);
        send_transaction(OP_NEW_FILE, 8'h0A, '0);
        read_bin('0);
        read_bin('1);

        // Word-length settings: zero, both ends of the range, random ones,
        // and the reset value again. Idle modes cycle through all four mixes.
        plan[0] = '0;
        plan[1] = 4'd15;
        plan[2] = 4'd1;
        plan[3] = WL_W'($urandom_range(3, 14));
        plan[4] = 4'd2;
        plan[5] = WL_W'($urandom_range(0, 15));
        plan[6] = WL_RESET;
        plan[7] = WL_W'($urandom_range(4, 9));
        for (i = 0; i < 8; i++)
        begin
            drain();
            write_word_length(plan[i]);
            feed_gaps     = (i % 4 == 0) || (i % 4 == 2);
            result_stalls = (i % 4 == 0) || (i % 4 == 1);
            run_phase(PHASE_ITEMS);
        end
        drain();

        $display("Run covered %0d transactions (%0d changing state) over nine word-length settings,",
                 sent_items, effective_items);
        $display("%0d words counted into the histogram and %0d bin reads checked.",
                 sb.words_counted, sb.reads_checked);
        if (sb.mismatches == 0 && sb.pending_reads.size() == 0)
            $display("Verification passed");
        else
        begin
            $display("ERROR: %0d mismatches, %0d reads never returned",
                     sb.mismatches, sb.pending_reads.size());
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("ERROR: timeout");
        $display("Verification failed");
        $finish;
    end

endmodule
